[design/lpr_pkg.sv]
// Package for the LRU page replacement block.
// Holds shared widths, defaults and the link store write enable type.
// No dependencies.
`default_nettype none

package lpr_pkg;

    localparam int PAGES_DEFAULT       = 128;
    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int PAGE_W              = 7;
    localparam int FRAME_W             = 8;
    localparam int HIT_COUNT_W         = 32;

    localparam logic [FRAME_W-1:0] FRAMES_RESET = 8'd128;

    typedef struct packed {
        logic res;
        logic older;
        logic newer;
    } lpr_we_t;

endpackage

`default_nettype wire

[design/lpr_store.sv]
// Link store: one synchronous memory word per page holding the resident bit
// and the older and newer links, with per-field writes and a registered read.
// Depends on lpr_pkg.
`default_nettype none

module lpr_store
    import lpr_pkg::*;
#(
    parameter int PAGES = PAGES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(PAGES)-1:0]         rd_addr,
    output logic      [2*$clog2(PAGES+1):0]       rd_data,
    input  wire lpr_we_t                          we,
    input  wire logic [$clog2(PAGES)-1:0]         wr_addr,
    input  wire logic                             wr_res,
    input  wire logic [$clog2(PAGES+1)-1:0]       wr_older,
    input  wire logic [$clog2(PAGES+1)-1:0]       wr_newer
);

    localparam int LW = $clog2(PAGES + 1);
    localparam int WW = 2 * LW + 1;

    logic [WW-1:0] mem [PAGES];
    logic [WW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we.res)
        begin
            mem[wr_addr][2*LW] <= wr_res;
        end
        if (we.older)
        begin
            mem[wr_addr][2*LW-1:LW] <= wr_older;
        end
        if (we.newer)
        begin
            mem[wr_addr][LW-1:0] <= wr_newer;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/lpr_ctrl.sv]
// Sequencer for the LRU page replacement block: list head and tail, frame and
// hit counters, clearing sweep and the read-modify-write steps on the link store.
// Depends on lpr_pkg; drives lpr_store.
`default_nettype none

module lpr_ctrl
    import lpr_pkg::*;
#(
    parameter int PAGES       = PAGES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [PAGE_W-1:0]            page,
    input  wire logic                         start_run,
    input  wire logic [FRAME_W-1:0]           limit,
    output logic                              done,
    output logic                              hit,
    output logic                              evicted,
    output logic [PAGE_W-1:0]                 evicted_page,
    output logic [COUNT_WIDTH-1:0]            hits,
    output logic                              rd_en,
    output logic [$clog2(PAGES)-1:0]          rd_addr,
    input  wire logic [2*$clog2(PAGES+1):0]   rd_data,
    output lpr_we_t                           we,
    output logic [$clog2(PAGES)-1:0]          wr_addr,
    output logic                              wr_res,
    output logic [$clog2(PAGES+1)-1:0]        wr_older,
    output logic [$clog2(PAGES+1)-1:0]        wr_newer
);

    localparam int PW = $clog2(PAGES);
    localparam int LW = $clog2(PAGES + 1);
    localparam int XW = (LW > PAGE_W) ? LW : PAGE_W;
    localparam logic [LW-1:0] NIL = LW'(PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(PAGES - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_DECIDE,
        ST_VREAD,
        ST_VDEC,
        ST_V2,
        ST_H1,
        ST_H2,
        ST_A1,
        ST_A2,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [PW-1:0]          page_reg, page_next;
    logic                   in_range_reg, in_range_next;
    logic                   pending_reg, pending_next;
    logic [PW-1:0]          sweep_reg, sweep_next;
    logic [LW-1:0]          oldest_reg, oldest_next;
    logic [LW-1:0]          newest_reg, newest_next;
    logic [LW-1:0]          older_reg, older_next;
    logic [LW-1:0]          newer_reg, newer_next;
    logic [FRAME_W-1:0]     frames_reg, frames_next;
    logic [COUNT_WIDTH-1:0] hits_reg, hits_next;
    logic                   hit_reg, hit_next;
    logic                   evicted_reg, evicted_next;
    logic [PAGE_W-1:0]      evp_reg, evp_next;

    logic [XW-1:0]          page_ext;
    logic                   rd_res;
    logic [LW-1:0]          rd_older;
    logic [LW-1:0]          rd_newer;

    assign page_ext = XW'(page);
    assign rd_res   = rd_data[2*LW];
    assign rd_older = rd_data[2*LW-1:LW];
    assign rd_newer = rd_data[LW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        page_next     = page_reg;
        in_range_next = in_range_reg;
        pending_next  = pending_reg;
        sweep_next    = sweep_reg;
        oldest_next   = oldest_reg;
        newest_next   = newest_reg;
        older_next    = older_reg;
        newer_next    = newer_reg;
        frames_next   = frames_reg;
        hits_next     = hits_reg;
        hit_next      = hit_reg;
        evicted_next  = evicted_reg;
        evp_next      = evp_reg;
        rd_en         = 1'b0;
        rd_addr       = page_reg;
        we            = '0;
        wr_addr       = page_reg;
        wr_res        = 1'b0;
        wr_older      = NIL;
        wr_newer      = NIL;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    page_next     = page_ext[PW-1:0];
                    in_range_next = page_ext < XW'(PAGES);
                    hit_next      = 1'b0;
                    evicted_next  = 1'b0;
                    evp_next      = '0;
                    if (start_run)
                    begin
                        oldest_next  = NIL;
                        newest_next  = NIL;
                        frames_next  = '0;
                        hits_next    = '0;
                        sweep_next   = '0;
                        pending_next = 1'b1;
                        state_next   = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_CLEAR:
            begin
                we.res  = 1'b1;
                wr_addr = sweep_reg;
                wr_res  = 1'b0;
                if (sweep_reg == LAST_PAGE)
                begin
                    pending_next = 1'b0;
                    state_next   = pending_reg ? ST_READ : ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                if (in_range_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = page_reg;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DECIDE:
            begin
                if (rd_res)
                begin
                    hit_next = 1'b1;
                    if (~&hits_reg)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                    older_next = rd_older;
                    newer_next = rd_newer;
                    state_next = (rd_newer < NIL) ? ST_H1 : ST_DONE;
                end
                else if ((frames_reg < limit) || !(oldest_reg < NIL))
                begin
                    if (~&frames_reg)
                    begin
                        frames_next = frames_reg + 1'b1;
                    end
                    state_next = ST_A1;
                end
                else
                begin
                    evicted_next = 1'b1;
                    evp_next     = PAGE_W'(oldest_reg);
                    state_next   = ST_VREAD;
                end
            end
            ST_VREAD:
            begin
                rd_en      = 1'b1;
                rd_addr    = oldest_reg[PW-1:0];
                state_next = ST_VDEC;
            end
            ST_VDEC:
            begin
                we.res      = 1'b1;
                wr_addr     = oldest_reg[PW-1:0];
                wr_res      = 1'b0;
                oldest_next = rd_newer;
                newer_next  = rd_newer;
                if (rd_newer < NIL)
                begin
                    state_next = ST_V2;
                end
                else
                begin
                    newest_next = NIL;
                    state_next  = ST_A1;
                end
            end
            ST_V2:
            begin
                we.older   = 1'b1;
                wr_addr    = newer_reg[PW-1:0];
                wr_older   = NIL;
                state_next = ST_A1;
            end
            ST_H1:
            begin
                if (older_reg < NIL)
                begin
                    we.newer = 1'b1;
                    wr_addr  = older_reg[PW-1:0];
                    wr_newer = newer_reg;
                end
                else
                begin
                    oldest_next = newer_reg;
                end
                state_next = ST_H2;
            end
            ST_H2:
            begin
                we.older   = 1'b1;
                wr_addr    = newer_reg[PW-1:0];
                wr_older   = older_reg;
                state_next = ST_A1;
            end
            ST_A1:
            begin
                we       = '{res: 1'b1, older: 1'b1, newer: 1'b1};
                wr_addr  = page_reg;
                wr_res   = 1'b1;
                wr_older = newest_reg;
                wr_newer = NIL;
                if (newest_reg < NIL)
                begin
                    state_next = ST_A2;
                end
                else
                begin
                    oldest_next = LW'(page_reg);
                    newest_next = LW'(page_reg);
                    state_next  = ST_DONE;
                end
            end
            ST_A2:
            begin
                we.newer    = 1'b1;
                wr_addr     = newest_reg[PW-1:0];
                wr_newer    = LW'(page_reg);
                newest_next = LW'(page_reg);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pending_reg  <= 1'b0;
            sweep_reg    <= '0;
            oldest_reg   <= NIL;
            newest_reg   <= NIL;
            frames_reg   <= '0;
            hits_reg     <= '0;
            hit_reg      <= 1'b0;
            evicted_reg  <= 1'b0;
            evp_reg      <= '0;
            in_range_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            sweep_reg    <= sweep_next;
            oldest_reg   <= oldest_next;
            newest_reg   <= newest_next;
            frames_reg   <= frames_next;
            hits_reg     <= hits_next;
            hit_reg      <= hit_next;
            evicted_reg  <= evicted_next;
            evp_reg      <= evp_next;
            in_range_reg <= in_range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        older_reg <= older_next;
        newer_reg <= newer_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign done         = state_reg == ST_DONE;
    assign hit          = hit_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evp_reg;
    assign hits         = hits_reg;

endmodule

`default_nettype wire

[design/lru_page_replacement.sv]
// LRU page replacement, top level: frame limit register, sequencer and link store.
// Depends on lpr_pkg, lpr_ctrl and lpr_store.
// A result is strobed on done after the transfer edge, once the link store reads and writes that
// the reference needs are through; a start is taken again the cycle after.
// A reference with start_run first sweeps the store, one page a cycle.
// After reset the same sweep runs with busy high. Results cannot be stalled.
`default_nettype none

module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int PAGES       = PAGES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [PAGE_W-1:0]        page,
    input  wire logic                     start_run,
    input  wire logic                     cfg_wr_en,
    input  wire logic [FRAME_W-1:0]       cfg_wr_data,
    output logic                          done,
    output logic                          hit,
    output logic                          evicted,
    output logic [PAGE_W-1:0]             evicted_page,
    output logic [HIT_COUNT_W-1:0]        hit_count
);

    localparam int PW = $clog2(PAGES);
    localparam int LW = $clog2(PAGES + 1);

    logic [FRAME_W-1:0]     frames_in_use_reg;
    logic [FRAME_W-1:0]     limit;
    logic [COUNT_WIDTH-1:0] hits;
    logic                   rd_en;
    logic [PW-1:0]          rd_addr;
    logic [2*LW:0]          rd_data;
    lpr_we_t                we;
    logic [PW-1:0]          wr_addr;
    logic                   wr_res;
    logic [LW-1:0]          wr_older;
    logic [LW-1:0]          wr_newer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_RESET;
        end
        else if (cfg_wr_en)
        begin
            frames_in_use_reg <= cfg_wr_data;
        end
    end

    // A frame limit of zero behaves as one frame.
    assign limit = (frames_in_use_reg == '0) ? FRAME_W'(1) : frames_in_use_reg;

    lpr_ctrl #(
        .PAGES       (PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .page         (page),
        .start_run    (start_run),
        .limit        (limit),
        .done         (done),
        .hit          (hit),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hits         (hits),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .we           (we),
        .wr_addr      (wr_addr),
        .wr_res       (wr_res),
        .wr_older     (wr_older),
        .wr_newer     (wr_newer)
    );

    lpr_store #(
        .PAGES (PAGES)
    ) u_store (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .we       (we),
        .wr_addr  (wr_addr),
        .wr_res   (wr_res),
        .wr_older (wr_older),
        .wr_newer (wr_newer)
    );

    assign hit_count = HIT_COUNT_W'(hits);

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block did not return to idle after a result");

    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("result strobed in the cycle after a transfer");

    a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted))
        else $error("a result reports both a hit and an eviction");

    a_evp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_page == '0))
        else $error("evicted page not zero without an eviction");

endmodule

`default_nettype wire

[bench/lru_page_replacement_tb.sv]
// Self-checking testbench for lru_page_replacement: a directed set, then random phases.
// Each transfer is scored against a behavioral LRU list kept inside the bench.
// Depends on lpr_pkg and the lru_page_replacement RTL.
`default_nettype none

module lru_page_replacement_tb
    import lpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PAGES = PAGES_DEFAULT;
    localparam logic [FRAME_W-1:0] NIL_PAGE = FRAME_W'(NUM_PAGES);
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [PAGE_W-1:0] page;
        logic              start_run;
        int unsigned       gap;
    } page_ref_t;

    typedef struct packed {
        logic                   hit;
        logic                   evicted;
        logic [PAGE_W-1:0]      evicted_page;
        logic [HIT_COUNT_W-1:0] hit_count;
    } lru_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [PAGE_W-1:0]      page = '0;
    logic                   start_run = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [FRAME_W-1:0]     cfg_wr_data = '0;
    logic                   busy;
    logic                   done;
    logic                   hit;
    logic                   evicted;
    logic [PAGE_W-1:0]      evicted_page;
    logic [HIT_COUNT_W-1:0] hit_count;

    page_ref_t   pending_refs[$];
    lru_result_t expected_results[$];
    logic        armed = 1'b0;
    int unsigned gap_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    logic                   lru_resident[NUM_PAGES];
    logic [FRAME_W-1:0]     lru_older[NUM_PAGES];
    logic [FRAME_W-1:0]     lru_newer[NUM_PAGES];
    logic [FRAME_W-1:0]     lru_oldest;
    logic [FRAME_W-1:0]     lru_newest;
    logic [FRAME_W-1:0]     lru_used;
    logic [HIT_COUNT_W-1:0] lru_hits;
    logic [FRAME_W-1:0]     lru_frames = FRAMES_RESET;

    lru_page_replacement uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .page         (page),
        .start_run    (start_run),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .hit          (hit),
        .evicted      (evicted),
        .evicted_page (evicted_page),
        .hit_count    (hit_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_lru();
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            lru_resident[i] = 1'b0;
            lru_older[i] = '0;
            lru_newer[i] = '0;
        end
        lru_oldest = NIL_PAGE;
        lru_newest = NIL_PAGE;
        lru_used = '0;
        lru_hits = '0;
    endfunction

    function automatic void unlink_lru(logic [FRAME_W-1:0] p);
        logic [FRAME_W-1:0] o;
        logic [FRAME_W-1:0] n;
        o = lru_older[p];
        n = lru_newer[p];
        if (o < NIL_PAGE)
            lru_newer[o] = n;
        else
            lru_oldest = n;
        if (n < NIL_PAGE)
            lru_older[n] = o;
        else
            lru_newest = o;
    endfunction

    function automatic void append_lru(logic [FRAME_W-1:0] p);
        lru_older[p] = lru_newest;
        lru_newer[p] = NIL_PAGE;
        if (lru_newest < NIL_PAGE)
            lru_newer[lru_newest] = p;
        else
            lru_oldest = p;
        lru_newest = p;
    endfunction

    function automatic lru_result_t reference_page(logic [PAGE_W-1:0] pg, logic clr);
        lru_result_t        r;
        int unsigned        limit;
        logic [FRAME_W-1:0] p;
        logic [FRAME_W-1:0] victim;
        r = '0;
        p = FRAME_W'(pg);
        limit = (lru_frames == 0) ? 1 : lru_frames;
        if (clr)
            clear_lru();
        if (lru_resident[p])
        begin
            r.hit = 1'b1;
            if (lru_hits != '1)
                lru_hits = lru_hits + 1'b1;
            if (lru_newer[p] < NIL_PAGE)
            begin
                unlink_lru(p);
                append_lru(p);
            end
        end
        else if (lru_used < limit || lru_oldest >= NIL_PAGE)
        begin
            if (lru_used != '1)
                lru_used = lru_used + 1'b1;
            lru_resident[p] = 1'b1;
            append_lru(p);
        end
        else
        begin
            victim = lru_oldest;
            unlink_lru(victim);
            lru_resident[victim] = 1'b0;
            r.evicted = 1'b1;
            r.evicted_page = PAGE_W'(victim);
            lru_resident[p] = 1'b1;
            append_lru(p);
        end
        r.hit_count = lru_hits;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            armed <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(reference_page(page, start_run));
            if (start && busy)
                start <= 1'b1;
            else if (armed)
            begin
                if (gap_left == 0)
                begin
                    start <= 1'b1;
                    armed <= 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end
            end
            else if (pending_refs.size() != 0)
            begin
                page_ref_t nxt;
                nxt = pending_refs.pop_front();
                page <= nxt.page;
                start_run <= nxt.start_run;
                if (nxt.gap == 0)
                    start <= 1'b1;
                else
                begin
                    start <= 1'b0;
                    armed <= 1'b1;
                    gap_left <= nxt.gap - 1;
                end
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [HIT_COUNT_W-1:0] want,
                               logic [HIT_COUNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d actual %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result: expected none actual hit %0b evicted %0b",
                         $realtime, hit, evicted);
            end
            else
            begin
                lru_result_t want;
                want = expected_results.pop_front();
                check_field("hit", HIT_COUNT_W'(want.hit), HIT_COUNT_W'(hit));
                check_field("evicted", HIT_COUNT_W'(want.evicted), HIT_COUNT_W'(evicted));
                check_field("evicted_page", HIT_COUNT_W'(want.evicted_page),
                            HIT_COUNT_W'(evicted_page));
                check_field("hit_count", want.hit_count, hit_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("lru_page_replacement_tb: errors");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_refs.size() != 0 || armed || start || done || busy ||
               expected_results.size() != 0);
    endtask

    task automatic write_frames(logic [FRAME_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lru_frames = value;
        @(negedge clk);
    endtask

    function automatic void add_ref(logic [PAGE_W-1:0] pg, logic clr);
        page_ref_t it;
        it.page = pg;
        it.start_run = clr;
        it.gap = $urandom_range(0, 8);
        pending_refs.push_back(it);
    endfunction

    function automatic void add_random_phase(int count, bit clear_first, bit calm);
        page_ref_t   it;
        int unsigned lim;
        int unsigned span;
        int unsigned base;
        lim = (lru_frames == 0) ? 1 : lru_frames;
        if (lim > NUM_PAGES)
            lim = NUM_PAGES;
        span = lim + $urandom_range(0, 3);
        if (span > NUM_PAGES)
            span = NUM_PAGES;
        base = $urandom_range(0, NUM_PAGES - 1);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 65)
                it.page = PAGE_W'((base + $urandom_range(0, span - 1)) % NUM_PAGES);
            else
                it.page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
            it.start_run = (k == 0 && clear_first) || ($urandom_range(0, 99) < 2);
            if (calm || $urandom_range(0, 1) == 0)
                it.gap = 0;
            else
                it.gap = $urandom_range(0, 8);
            if (k % 37 == 36)
                base = $urandom_range(0, NUM_PAGES - 1);
            pending_refs.push_back(it);
        end
    endfunction

    initial
    begin
        logic [FRAME_W-1:0] limits[14];
        limits = '{8'd128, 8'd1, 8'd2, 8'd255, 8'd0, 8'd4, 8'd16, 8'd127, 8'd64, 8'd3,
                   8'd200, 8'd32, 8'd8, 8'd100};
        clear_lru();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        write_frames(8'd3);
        add_ref(7'd0, 1'b1);
        add_ref(7'd127, 1'b0);
        add_ref(7'd0, 1'b0);
        add_ref(7'd5, 1'b0);
        add_ref(7'd64, 1'b0);
        add_ref(7'd0, 1'b0);
        add_ref(7'd127, 1'b0);
        add_ref(7'd127, 1'b0);
        wait_idle();

        // Lowering the limit mid-run keeps the resident pages and forces evictions.
        write_frames(8'd1);
        add_ref(7'd64, 1'b0);
        add_ref(7'd1, 1'b0);
        add_ref(7'd2, 1'b0);
        wait_idle();

        write_frames(8'd0);
        add_ref(7'd3, 1'b1);
        add_ref(7'd3, 1'b0);
        add_ref(7'd9, 1'b0);
        add_ref(7'd3, 1'b0);
        wait_idle();

        write_frames(8'd255);
        add_ref(7'd127, 1'b1);
        add_ref(7'd0, 1'b0);
        add_ref(7'd127, 1'b0);
        add_ref(7'd85, 1'b0);
        add_ref(7'd42, 1'b0);
        add_ref(7'd0, 1'b0);
        wait_idle();

        foreach (limits[i])
        begin
            write_frames(limits[i]);
            add_random_phase(135, i % 3 != 1, i % 4 == 2);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("lru_page_replacement_tb: clean");
        else
            $display("lru_page_replacement_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/lpr_pkg.sv
design/lpr_store.sv
design/lpr_ctrl.sv
design/lru_page_replacement.sv
bench/lru_page_replacement_tb.sv
